[rtl/lmce_pkg.sv]
// Shared types and constants for the longest-match character-map encoder.
`default_nettype none
package lmce_pkg;

	localparam int TABLE_ENTRIES = 256;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = IDX_W + 1;
	localparam int CODE_W        = 21;
	localparam int WINDOW        = 3;
	localparam int KEY_W         = CODE_W * WINDOW;
	localparam logic [7:0] TERMINATOR = 8'hFF;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_MATCH = 2'd1,
		ST_DUP      = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_LDONE,
		S_MATCHED,
		S_BYTE2,
		S_TERM,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0] codes;
		logic [1:0]       klen;
		logic [1:0]       bcnt;
		logic [7:0]       b2;
		logic [7:0]       b1;
	} entry_t;

	typedef struct packed {
		logic [7:0] out_byte;
		status_t    status;
		logic       last;
	} res_t;

	typedef struct packed {
		logic       found;
		logic       dup;
		logic [1:0] best_len;
		logic [1:0] best_cnt;
		logic [7:0] best_b2;
		logic [7:0] best_b1;
	} match_t;

endpackage
`default_nettype wire

[rtl/lmce_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lmce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[rtl/lmce_match.sv]
// Key compare unit: checks each scanned entry, keeps the best hit and flags duplicate load keys.
`default_nettype none
module lmce_match
	import lmce_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             clear,
	input  wire logic             rd_valid,
	input  wire entry_t           rd_entry,
	input  wire logic             is_load,
	input  wire logic [KEY_W-1:0] key,
	input  wire logic [1:0]       klen,
	input  wire logic [KEY_W-1:0] win,
	input  wire logic [1:0]       maxlen,
	output match_t                m
);

	logic found_q, dup_q;
	logic [1:0] len_q, cnt_q;
	logic [7:0] b1_q, b2_q;
	logic eq0, eq1, eq2, pre_hit, enc_hit, load_hit;

	always_comb begin
		eq0 = rd_entry.codes[CODE_W-1:0] == win[CODE_W-1:0];
		eq1 = rd_entry.codes[2*CODE_W-1:CODE_W] == win[2*CODE_W-1:CODE_W];
		eq2 = rd_entry.codes[3*CODE_W-1:2*CODE_W] == win[3*CODE_W-1:2*CODE_W];
		pre_hit = eq0 && (rd_entry.klen < 2'd2 || eq1) && (rd_entry.klen < 2'd3 || eq2);
		enc_hit = rd_valid && !is_load && rd_entry.klen != 2'd0
			&& rd_entry.klen <= maxlen && rd_entry.klen > len_q && pre_hit;
		load_hit = rd_valid && is_load && rd_entry.klen == klen && rd_entry.codes == key;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			dup_q   <= 1'b0;
			len_q   <= 2'd0;
		end else if (clear) begin
			found_q <= 1'b0;
			dup_q   <= 1'b0;
			len_q   <= 2'd0;
		end else begin
			if (load_hit) begin
				dup_q <= 1'b1;
			end
			if (enc_hit) begin
				found_q <= 1'b1;
				len_q   <= rd_entry.klen;
			end
		end
	end

	// Payload of the best hit; valid only alongside found_q.
	always_ff @(posedge clk) begin
		if (enc_hit) begin
			cnt_q <= rd_entry.bcnt;
			b1_q  <= rd_entry.b1;
			b2_q  <= rd_entry.b2;
		end
	end

	assign m = '{found: found_q, dup: dup_q, best_len: len_q, best_cnt: cnt_q,
		best_b2: b2_q, best_b1: b1_q};

endmodule
`default_nettype wire

[rtl/longest_match_charmap_encoder.sv]
// Top level of the greedy longest-match character-map encoder.
`default_nettype none
// Load items (mode 0) append an entry to a 256-entry table held in one
// synchronous RAM unless the key is a duplicate or the table is full; each
// load first scans all loaded entries for a duplicate key and returns exactly
// one status result. Encode items (mode 1) push a code point into a
// three-deep lookahead (one deep with single_only). When the lookahead is
// full or end_of_string is set, the table is scanned once per match: one
// entry is read per cycle and all prefix lengths are compared in parallel.
// A match goes through the check, the scan with its registered read and
// compare, and the first byte; a second byte adds one more state. An encode
// item takes up to three table scans. One item is worked on at a time;
// in_ready is high only when the sequencer is idle. Results go through a
// one-deep holding stage and an output register, so the block takes the
// next item while the final result still waits for transfer. last_of_run
// marks the final result of an item; an encode item that neither fills the
// lookahead nor ends a string gives no result. No clearing pass is needed
// after reset.
module longest_match_charmap_encoder
	import lmce_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              mode,
	input  wire logic [CODE_W-1:0] code_first,
	input  wire logic [CODE_W-1:0] code_second,
	input  wire logic [CODE_W-1:0] code_third,
	input  wire logic [1:0]        key_length,
	input  wire logic [1:0]        byte_count,
	input  wire logic [7:0]        byte_first,
	input  wire logic [7:0]        byte_second,
	input  wire logic              single_only,
	input  wire logic              end_of_string,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             out_byte,
	output logic [1:0]             status,
	output logic                   last_of_run
);

	state_t state_q, state_d;

	// Item registers.
	logic              mode_q, single_q, eos_q;
	logic [KEY_W-1:0]  key_q;
	logic [1:0]        klen_q, bcnt_q;
	logic [7:0]        b1_q, b2_q;

	// Lookahead window and table fill.
	logic [CODE_W-1:0] win_q [WINDOW];
	logic [1:0]        fill_q;
	logic [CNT_W-1:0]  cnt_q;

	// Scan control.
	logic [CNT_W-1:0]  addr_q;
	logic              rd_s1;

	// Result holding stage and output register.
	logic pend_valid_q, out_valid_q;
	res_t pend_q, out_q;

	logic accept, out_free, can_emit, clear;
	logic issue, scan_done, emit, finish_push, finish_done, ram_we, cond;
	logic [1:0] limit, maxlen, klen_n, bcnt_n;
	res_t emit_res;
	entry_t rd_entry, wr_entry;
	match_t m;
	logic [KEY_W-1:0] win_flat;
	logic [$bits(entry_t)-1:0] rd_raw;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign can_emit = !pend_valid_q || out_free;
	assign limit    = single_q ? 2'd1 : 2'(WINDOW);
	assign maxlen   = (fill_q < limit) ? fill_q : limit;
	assign cond     = fill_q != 2'd0 && (fill_q >= limit || eos_q);
	assign win_flat = {win_q[2], win_q[1], win_q[0]};
	assign clear    = accept || (state_q == S_CHECK && cond);
	assign scan_done = !issue && !rd_s1;

	// Normalize the load fields: zero length acts as one, byte count clamps to 1..2.
	assign klen_n = (key_length == 2'd0) ? 2'd1 : key_length;
	assign bcnt_n = (byte_count == 2'd0) ? 2'd1 : ((byte_count == 2'd3) ? 2'd2 : byte_count);

	// Output decode of the sequencer.
	always_comb begin
		in_ready    = 1'b0;
		issue       = 1'b0;
		emit        = 1'b0;
		emit_res    = '{out_byte: 8'd0, status: ST_OK, last: 1'b0};
		ram_we      = 1'b0;
		finish_push = 1'b0;
		finish_done = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
			end
			S_CHECK: begin
			end
			S_SCAN: begin
				issue = addr_q < cnt_q;
			end
			S_LDONE: begin
				emit = can_emit;
				if (m.dup) begin
					emit_res.status = ST_DUP;
				end else if (cnt_q[CNT_W-1]) begin
					emit_res.status = ST_FULL;
				end
				ram_we = emit && !m.dup && !cnt_q[CNT_W-1];
			end
			S_MATCHED: begin
				emit = can_emit;
				if (m.found) begin
					emit_res.out_byte = m.best_b1;
				end else begin
					emit_res.status = ST_NO_MATCH;
				end
			end
			S_BYTE2: begin
				emit = can_emit;
				emit_res.out_byte = m.best_b2;
			end
			S_TERM: begin
				emit = can_emit;
				emit_res.out_byte = TERMINATOR;
			end
			S_FINISH: begin
				finish_push = pend_valid_q && out_free;
				finish_done = !pend_valid_q || out_free;
			end
			default: begin
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = mode ? S_CHECK : S_SCAN;
				end
			end
			S_CHECK: begin
				if (cond) begin
					state_d = S_SCAN;
				end else if (eos_q) begin
					state_d = S_TERM;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_SCAN: begin
				if (scan_done) begin
					state_d = mode_q ? S_MATCHED : S_LDONE;
				end
			end
			S_LDONE: begin
				if (emit) begin
					state_d = S_FINISH;
				end
			end
			S_MATCHED: begin
				if (emit) begin
					if (m.found) begin
						state_d = (m.best_cnt >= 2'd2) ? S_BYTE2 : S_CHECK;
					end else begin
						state_d = eos_q ? S_TERM : S_FINISH;
					end
				end
			end
			S_BYTE2: begin
				if (emit) begin
					state_d = S_CHECK;
				end
			end
			S_TERM: begin
				if (emit) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (finish_done) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Latch the item fields on transfer.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= mode;
			single_q <= single_only;
			eos_q    <= end_of_string;
			klen_q   <= klen_n;
			bcnt_q   <= bcnt_n;
			b1_q     <= byte_first;
			b2_q     <= byte_second;
			key_q    <= {(klen_n == 2'd3) ? code_third : CODE_W'(0),
				(klen_n >= 2'd2) ? code_second : CODE_W'(0), code_first};
		end
	end

	// Scan address and read pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			rd_s1  <= 1'b0;
		end else begin
			rd_s1 <= issue;
			if (clear) begin
				addr_q <= '0;
			end else if (issue) begin
				addr_q <= addr_q + CNT_W'(1);
			end
		end
	end

	// Table fill count: advance on each stored entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ram_we) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// Lookahead: push on encode transfer, drop matched code points, clear on miss.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 2'd0;
			for (int k = 0; k < WINDOW; k++) begin
				win_q[k] <= '0;
			end
		end else if (accept && mode) begin
			if (fill_q < 2'(WINDOW)) begin
				win_q[fill_q] <= code_first;
				fill_q        <= fill_q + 2'd1;
			end
		end else if (state_q == S_MATCHED && emit) begin
			if (m.found) begin
				case (m.best_len)
					2'd1: begin
						win_q[0] <= win_q[1];
						win_q[1] <= win_q[2];
					end
					2'd2: begin
						win_q[0] <= win_q[2];
					end
					default: begin
					end
				endcase
				fill_q <= fill_q - m.best_len;
			end else begin
				fill_q <= 2'd0;
			end
		end
	end

	// Holding stage keeps the newest result until it is known whether it is last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (emit) begin
				pend_valid_q <= 1'b1;
			end else if (finish_push) begin
				pend_valid_q <= 1'b0;
			end
			if ((emit && pend_valid_q) || finish_push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pend_q <= emit_res;
		end
		if (emit && pend_valid_q) begin
			out_q <= pend_q;
		end else if (finish_push) begin
			out_q <= '{out_byte: pend_q.out_byte, status: pend_q.status, last: 1'b1};
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_q.out_byte;
	assign status      = out_q.status;
	assign last_of_run = out_q.last;

	assign wr_entry = '{codes: key_q, klen: klen_q, bcnt: bcnt_q, b2: b2_q, b1: b1_q};
	assign rd_entry = entry_t'(rd_raw);

	lmce_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[IDX_W-1:0]),
		.wdata (wr_entry),
		.raddr (addr_q[IDX_W-1:0]),
		.rdata (rd_raw)
	);

	lmce_match u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (clear),
		.rd_valid (rd_s1),
		.rd_entry (rd_entry),
		.is_load  (!mode_q),
		.key      (key_q),
		.klen     (klen_q),
		.win      (win_flat),
		.maxlen   (maxlen),
		.m        (m)
	);

	// The table never holds more than its capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TABLE_ENTRIES))
		else $error("table fill count beyond capacity");

	// Every stored entry advances the fill count by one.
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("fill count did not follow a table write");

	// No result is left in the holding stage once the sequencer is idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !pend_valid_q)
		else $error("result stranded in holding stage");

	// A transfer always starts work on the item.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("accepted item not started");

endmodule
`default_nettype wire
